### sv/id_bitmap_allocator_defines.svh
// Assertion macros used by the checker file.
`ifndef ID_BITMAP_ALLOCATOR_DEFINES_SVH
`define ID_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("id allocator check failed");

// Next-cycle implication, disabled while reset is held.
`define IBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("id allocator check failed");

`endif

### sv/iba_pkg.sv
package iba_pkg;

    // Field widths
    localparam int ID_W   = 10;
    localparam int ST_W   = 2;
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    // Defaults
    localparam int ID_SLOTS_DEF = 1024;
    localparam logic [ID_W-1:0] LOWEST_RST  = ID_W'(100);
    localparam logic [ID_W-1:0] HIGHEST_RST = ID_W'(1000);

    // Commands
    localparam logic CMD_ALLOCATE = 1'b0;
    localparam logic CMD_RELEASE  = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_GRANTED      = 2'd0;
    localparam logic [ST_W-1:0] ST_EXHAUSTED    = 2'd1;
    localparam logic [ST_W-1:0] ST_RELEASED     = 2'd2;
    localparam logic [ST_W-1:0] ST_OUT_OF_RANGE = 2'd3;

    // Register indexes
    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_REL
    } t_state;

    // Lowest set bit of a word
    function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (w[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### sv/iba_bitmap.sv
module iba_bitmap
    import iba_pkg::*;
#(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [AW-1:0]     i_rd_addr,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data,
    output logic [WORD_W-1:0] o_rd_data
);

    logic [WORD_W-1:0] r_mem [WORDS];
    logic [WORDS-1:0]  r_wvld;
    logic [WORD_W-1:0] r_rd_data;
    logic              r_rd_vld;

    // Word storage, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
        r_rd_vld  <= r_wvld[i_rd_addr];
    end

    // Per-word written flags; an unwritten word reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvld <= '0;
        end else if (i_wr_en) begin
            r_wvld[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### sv/id_bitmap_allocator.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   -------------------------------
// command   i_cmd, i_release_id                     taken when start && !busy
// result    o_granted_id, o_status                  o_valid for one cycle, no stall
// config    psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// Allocate: the bitmap is read one 32-bit word per cycle from a memory with one
// read and one write port; the result is registered once a free slot in range
// is found or the range is used up. busy drops as the result goes out.
// An empty range answers in the cycle after start. Release: out of range answers
// in the cycle after start; in range the word is read, then written in S_REL.
// Reset clears the per-word written flags at once; no clearing pass is needed.
module id_bitmap_allocator
    import iba_pkg::*;
#(
    parameter int ID_SLOTS = ID_SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  logic            i_cmd,
    input  logic [ID_W-1:0] i_release_id,
    output logic            o_valid,
    output logic [ID_W-1:0] o_granted_id,
    output logic [ST_W-1:0] o_status,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int WORDS = (ID_SLOTS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int CNT_W = $clog2(ID_SLOTS + 1);
    localparam int CMP_W = ((CNT_W > ID_W) ? CNT_W : ID_W) + 6;

    t_state            r_state, n_state;
    logic [ID_W-1:0]   r_lowest, r_highest;
    logic [AW-1:0]     r_addr, n_addr;
    logic [BIT_W-1:0]  r_bit, n_bit;
    logic              r_valid, n_valid;
    logic [ID_W-1:0]   r_granted, n_granted;
    logic [ST_W-1:0]   r_status, n_status;

    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_word;

    logic [CMP_W-1:0]  range_n;
    logic [ID_W-1:0]   rel_diff;
    logic              rel_bad;
    logic [CMP_W-1:0]  rem;
    logic [WORD_W-1:0] free_mask;
    logic [BIT_W-1:0]  free_idx;
    logic [AW+BIT_W-1:0] slot;
    logic              cfg_wr;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_HIGHEST) ? 32'(r_highest) : 32'(r_lowest);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest  <= LOWEST_RST;
            r_highest <= HIGHEST_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOWEST) begin
                r_lowest <= pwdata[ID_W-1:0];
            end else begin
                r_highest <= pwdata[ID_W-1:0];
            end
        end
    end

    // Slots in range, capped at the map size
    always_comb begin
        range_n = CMP_W'(r_highest) - CMP_W'(r_lowest) + CMP_W'(1);
        if (r_highest < r_lowest) begin
            range_n = '0;
        end else if (range_n > CMP_W'(ID_SLOTS)) begin
            range_n = CMP_W'(ID_SLOTS);
        end
    end

    // Release range check
    assign rel_diff = i_release_id - r_lowest;
    assign rel_bad  = (i_release_id < r_lowest) || (i_release_id > r_highest) ||
                      (CMP_W'(rel_diff) >= CMP_W'(ID_SLOTS));

    // Scan lanes: free slots of the current word that lie in range
    assign rem = range_n - CMP_W'({r_addr, {BIT_W{1'b0}}});
    always_comb begin
        for (int b = 0; b < WORD_W; b++) begin
            free_mask[b] = !rd_word[b] && (CMP_W'(b) < rem);
        end
    end
    assign free_idx = first_one(free_mask);
    assign slot     = {r_addr, free_idx};

    iba_bitmap #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_word)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    // Work registers and result payload
    always_ff @(posedge i_clk) begin
        r_addr    <= n_addr;
        r_bit     <= n_bit;
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_bit     = r_bit;
        n_valid   = 1'b0;
        n_granted = r_granted;
        n_status  = r_status;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_data   = rd_word;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == CMD_ALLOCATE) begin
                        if (range_n == '0) begin
                            n_valid   = 1'b1;
                            n_granted = '0;
                            n_status  = ST_EXHAUSTED;
                        end else begin
                            rd_addr = '0;
                            n_addr  = '0;
                            n_state = S_SCAN;
                        end
                    end else if (rel_bad) begin
                        n_valid   = 1'b1;
                        n_granted = '0;
                        n_status  = ST_OUT_OF_RANGE;
                    end else begin
                        rd_addr = AW'(rel_diff >> BIT_W);
                        n_addr  = AW'(rel_diff >> BIT_W);
                        n_bit   = rel_diff[BIT_W-1:0];
                        n_state = S_REL;
                    end
                end
            end
            S_SCAN: begin
                if (|free_mask) begin
                    wr_en     = 1'b1;
                    wr_data   = rd_word | (WORD_W'(1) << free_idx);
                    n_valid   = 1'b1;
                    n_granted = r_lowest + ID_W'(slot);
                    n_status  = ST_GRANTED;
                    n_state   = S_IDLE;
                end else if (rem <= CMP_W'(WORD_W)) begin
                    n_valid   = 1'b1;
                    n_granted = '0;
                    n_status  = ST_EXHAUSTED;
                    n_state   = S_IDLE;
                end else begin
                    rd_addr = r_addr + AW'(1);
                    n_addr  = r_addr + AW'(1);
                end
            end
            S_REL: begin
                wr_en     = 1'b1;
                wr_data   = rd_word & ~(WORD_W'(1) << r_bit);
                n_valid   = 1'b1;
                n_granted = '0;
                n_status  = ST_RELEASED;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_valid;
    assign o_granted_id = r_granted;
    assign o_status     = r_status;

endmodule

### sv/iba_chk.sv
`include "id_bitmap_allocator_defines.svh"

module iba_chk
    import iba_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            start,
    input logic            busy,
    input logic            o_valid,
    input logic [ID_W-1:0] o_granted_id,
    input logic [ST_W-1:0] o_status
);

    // An accepted item is either answered next cycle or still in work
    `IBA_ASSERT_NXT(a_accept_progress, i_clk, i_rst_n, start && !busy, o_valid || busy)

    // A result always leaves the block ready for the next item
    `IBA_ASSERT_IMP(a_result_idle, i_clk, i_rst_n, o_valid, !busy)

    // An in-range release needs its read-modify-write cycle
    `IBA_ASSERT_IMP(a_release_rmw, i_clk, i_rst_n, o_valid && (o_status == ST_RELEASED), $past(busy))

    // Only a grant carries an identifier
    `IBA_ASSERT_IMP(a_zero_id, i_clk, i_rst_n, o_valid && (o_status != ST_GRANTED), o_granted_id == '0)

endmodule

bind id_bitmap_allocator iba_chk u_iba_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_granted_id (o_granted_id),
    .o_status     (o_status)
);

### tb/id_bitmap_allocator_test.sv
module id_bitmap_allocator_test;
    import iba_pkg::*;

    localparam int NUM_SLOTS    = 1024;
    localparam int RANDOM_ITEMS = 1125;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 2;

    // Kinds of entries the driver works through
    typedef enum logic [1:0] {
        REQ_COMMAND,
        REQ_REG_WRITE,
        REQ_DRAIN
    } req_kind_t;

    typedef struct {
        req_kind_t       kind;
        logic            cmd;
        logic [ID_W-1:0] rid;
        logic            reg_sel;
        logic [31:0]     value;
    } alloc_req_t;

    typedef struct {
        logic [ID_W-1:0] granted;
        logic [ST_W-1:0] status;
    } id_result_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    logic            i_cmd = CMD_ALLOCATE;
    logic [ID_W-1:0] i_release_id = '0;
    logic            o_valid;
    logic [ID_W-1:0] o_granted_id;
    logic [ST_W-1:0] o_status;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    // Requests waiting for the driver, and results owed by the block
    alloc_req_t requests[$];
    id_result_t owed_results[$];

    // Shadow of the allocator state
    bit              slot_taken [NUM_SLOTS];
    logic [ID_W-1:0] cfg_lowest  = LOWEST_RST;
    logic [ID_W-1:0] cfg_highest = HIGHEST_RST;

    int error_count = 0;
    int cycle_count = 0;

    // Sender pacing
    int burst_left = 1;
    int gap_left = 0;
    int idle_cycles = 0;
    int apb_step = 0;

    id_bitmap_allocator #(
        .ID_SLOTS(NUM_SLOTS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_release_id (i_release_id),
        .o_valid      (o_valid),
        .o_granted_id (o_granted_id),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Work out the result of one accepted item and update the shadow bitmap
    function automatic void predict_allocation(input logic cmd, input logic [ID_W-1:0] rid);
        id_result_t res;
        int span;
        bit found;
        res.granted = '0;
        found = 1'b0;
        if (cfg_highest < cfg_lowest) begin
            span = 0;
        end else begin
            span = int'(cfg_highest) - int'(cfg_lowest) + 1;
        end
        if (span > NUM_SLOTS) begin
            span = NUM_SLOTS;
        end
        if (cmd == CMD_ALLOCATE) begin
            res.status = ST_EXHAUSTED;
            for (int i = 0; i < span && !found; i++) begin
                if (!slot_taken[i]) begin
                    slot_taken[i] = 1'b1;
                    res.granted = ID_W'(int'(cfg_lowest) + i);
                    res.status = ST_GRANTED;
                    found = 1'b1;
                end
            end
        end else if (rid < cfg_lowest || rid > cfg_highest
                     || (int'(rid) - int'(cfg_lowest)) >= NUM_SLOTS) begin
            res.status = ST_OUT_OF_RANGE;
        end else begin
            slot_taken[int'(rid) - int'(cfg_lowest)] = 1'b0;
            res.status = ST_RELEASED;
        end
        owed_results.push_back(res);
    endfunction

    function automatic void queue_command(input logic cmd, input int rid);
        alloc_req_t r;
        r.kind = REQ_COMMAND;
        r.cmd = cmd;
        r.rid = ID_W'(rid);
        r.reg_sel = REG_LOWEST;
        r.value = '0;
        requests.push_back(r);
    endfunction

    // Upper data bits are junk; only the low ID_W bits land in the register
    function automatic void queue_reg_write(input logic sel, input int value);
        alloc_req_t r;
        r.kind = REQ_REG_WRITE;
        r.cmd = CMD_ALLOCATE;
        r.rid = '0;
        r.reg_sel = sel;
        r.value = {22'($urandom()), ID_W'(value)};
        requests.push_back(r);
    endfunction

    function automatic void queue_drain();
        alloc_req_t r;
        r.kind = REQ_DRAIN;
        r.cmd = CMD_ALLOCATE;
        r.rid = '0;
        r.reg_sel = REG_LOWEST;
        r.value = '0;
        requests.push_back(r);
    endfunction

    // Driver: presents items in bursts, runs register writes once the block is idle
    always @(posedge i_clk) begin
        alloc_req_t head;
        logic presenting;
        if (i_rst_n) begin
            presenting = start;
            if (start && !busy) begin
                head = requests.pop_front();
                predict_allocation(head.cmd, head.rid);
                presenting = 1'b0;
            end
            if (apb_step == 1) begin
                penable <= 1'b1;
                apb_step = 2;
            end else if (apb_step == 2) begin
                // register is written at this edge
                head = requests.pop_front();
                if (head.reg_sel == REG_LOWEST) begin
                    cfg_lowest = head.value[ID_W-1:0];
                end else begin
                    cfg_highest = head.value[ID_W-1:0];
                end
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
                apb_step = 0;
            end else if (!presenting) begin
                if (requests.size() == 0) begin
                    start <= 1'b0;
                end else if (requests[0].kind == REQ_COMMAND) begin
                    if (gap_left > 0) begin
                        gap_left--;
                        start <= 1'b0;
                    end else begin
                        start <= 1'b1;
                        i_cmd <= requests[0].cmd;
                        i_release_id <= requests[0].rid;
                        burst_left--;
                        if (burst_left <= 0) begin
                            if ($urandom_range(0, 4) == 0) begin
                                // long stretch without idling
                                burst_left = $urandom_range(20, 40);
                                gap_left = 0;
                            end else begin
                                burst_left = $urandom_range(1, 12);
                                gap_left = ($urandom_range(0, 3) == 0) ? 0
                                                                       : $urandom_range(1, 45);
                            end
                        end
                    end
                end else begin
                    start <= 1'b0;
                    if (owed_results.size() == 0 && !busy) begin
                        idle_cycles++;
                    end else begin
                        idle_cycles = 0;
                    end
                    if (idle_cycles >= SETTLE_CYCLES) begin
                        idle_cycles = 0;
                        if (requests[0].kind == REQ_DRAIN) begin
                            void'(requests.pop_front());
                        end else begin
                            psel <= 1'b1;
                            pwrite <= 1'b1;
                            paddr <= {requests[0].reg_sel, 2'b00};
                            pwdata <= requests[0].value;
                            apb_step = 1;
                        end
                    end
                end
            end
        end
    end

    // Monitor: every strobed result is matched against the oldest owed one
    always @(posedge i_clk) begin
        id_result_t want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
                report_error($sformatf("unexpected result id %0d status %0d",
                                       o_granted_id, o_status));
            end else begin
                want = owed_results.pop_front();
                if (o_granted_id !== want.granted) begin
                    report_error($sformatf("granted_id %0d, want %0d",
                                           o_granted_id, want.granted));
                end
                if (o_status !== want.status) begin
                    report_error($sformatf("status %0d, want %0d", o_status, want.status));
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int lo;
        int hi;
        int made;
        int phase_len;
        int pick;

        // Default range 100..1000: grants, lowest-free reuse, out-of-range edges
        queue_command(CMD_RELEASE, 100);     // release of a free slot
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_RELEASE, 101);
        queue_command(CMD_ALLOCATE, 0);      // takes 101 back
        queue_command(CMD_RELEASE, 99);
        queue_command(CMD_RELEASE, 1001);
        queue_command(CMD_RELEASE, 0);
        queue_command(CMD_RELEASE, 1023);
        queue_command(CMD_RELEASE, 1000);
        queue_command(CMD_ALLOCATE, 1023);   // release_id ignored

        // One-slot range at the top; slot 0 is still held from before
        queue_reg_write(REG_LOWEST, 1023);
        queue_reg_write(REG_HIGHEST, 1023);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_RELEASE, 1023);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_ALLOCATE, 0);

        // Empty range
        queue_reg_write(REG_LOWEST, 600);
        queue_reg_write(REG_HIGHEST, 599);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_RELEASE, 600);
        queue_command(CMD_RELEASE, 599);

        // Full 10-bit range, identifier 0 handed out
        queue_reg_write(REG_LOWEST, 0);
        queue_reg_write(REG_HIGHEST, 1023);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_RELEASE, 0);
        queue_command(CMD_ALLOCATE, 0);
        queue_command(CMD_RELEASE, 1023);

        // Random phases, each under a fresh range
        made = 0;
        while (made < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: begin
                    lo = 0;
                    hi = 1023;
                end
                1: begin
                    lo = 0;
                    hi = 0;
                end
                2: begin
                    lo = 1023;
                    hi = 1023;
                end
                3: begin
                    lo = $urandom_range(1, 1023);
                    hi = $urandom_range(0, lo - 1);
                end
                4: begin
                    lo = LOWEST_RST;
                    hi = HIGHEST_RST;
                end
                default: begin
                    lo = $urandom_range(0, 1023);
                    hi = lo + $urandom_range(0, 31);
                    if (hi > 1023) begin
                        hi = 1023;
                    end
                end
            endcase
            if ($urandom_range(0, 1) == 0) begin
                queue_reg_write(REG_LOWEST, lo);
                queue_reg_write(REG_HIGHEST, hi);
            end else begin
                queue_reg_write(REG_HIGHEST, hi);
                queue_reg_write(REG_LOWEST, lo);
            end
            phase_len = $urandom_range(40, 120);
            for (int k = 0; k < phase_len; k++) begin
                if ($urandom_range(0, 99) < 55) begin
                    queue_command(CMD_ALLOCATE, $urandom_range(0, 1023));
                end else if (hi >= lo && $urandom_range(0, 4) != 0) begin
                    queue_command(CMD_RELEASE, lo + $urandom_range(0, hi - lo));
                end else begin
                    queue_command(CMD_RELEASE, $urandom_range(0, 1023));
                end
                made++;
                if (made == RANDOM_ITEMS / 2) begin
                    queue_drain();
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests.size() != 0 || owed_results.size() != 0 || start || busy) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
